// File: hw/rtl/usrm_pkg.sv
`timescale 1ns / 1ps

package usrm_pkg;

    // fixed field widths of the item on either side
    localparam int PRICE_IN_W = 32;
    localparam int MEAN_W     = 17;

    // input tdata layout
    localparam int PRICE_LSB    = 0;
    localparam int PRICE_OK_BIT = 32;
    localparam int HIGH_LSB     = 33;
    localparam int HIGH_OK_BIT  = 65;
    localparam int LOW_LSB      = 66;
    localparam int LOW_OK_BIT   = 98;
    localparam int S_TDATA_W    = 104;

    // output tdata layout
    localparam int MEAN_LSB    = 0;
    localparam int MEAN_OK_BIT = 17;
    localparam int M_TDATA_W   = 24;

    // divider command
    typedef struct packed {
        logic load;
        logic long_run;
    } div_ctl_t;

endpackage

// File: hw/rtl/usrm_div.sv
`timescale 1ns / 1ps

module usrm_div #(
    parameter int REM_W       = 32,
    parameter int DVD_W       = 29,
    parameter int QUO_W       = 17,
    parameter int SHORT_STEPS = 16,
    parameter int LONG_STEPS  = 29
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  usrm_pkg::div_ctl_t    ctl,
    input  logic [REM_W-1:0]      rem_init,
    input  logic [REM_W-1:0]      divisor,
    input  logic [DVD_W-1:0]      dividend,
    output logic                  done,
    output logic [QUO_W-1:0]      quotient
);
    import usrm_pkg::*;

    localparam int STEP_W = $clog2(LONG_STEPS + 1);

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W:0]    shifted;
    logic [REM_W:0]    diff;
    logic              ge;

    // one restoring step per cycle
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = ~diff[REM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.long_run ? STEP_W'(LONG_STEPS) : STEP_W'(SHORT_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= rem_init;
            dvs_reg <= divisor;
            dvd_reg <= dividend;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/upper_shadow_ratio_mean_unit.sv
`timescale 1ns / 1ps

// channel  dir  tdata (low bit up)                                       tuser         tlast
// s_       in   bar_price, price_ok, bar_high, high_ok, bar_low, low_ok  series_start  series_end
// m_       out  mean_ratio, mean_ok                                      -             -
//
// a skipped bar goes through range, shadow, check and finish back to idle; a counted bar
// also sends its ratio through the shared bit-serial divider, unless the ratio
// saturates at 1.0
// a series_end bar then runs the mean divide on the same divider (not when no bar was
// counted), and waits while an earlier result still sits in the output register
// synchronous active-low reset clears the sequencer, accumulators and output valid
// a result waiting on m_tready does not hold off the next input item

module upper_shadow_ratio_mean_unit #(
    parameter int PRICE_BITS      = 32,
    parameter int RATIO_FRAC_BITS = 16,
    parameter int MAX_BARS        = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bar_price, price_ok, bar_high, high_ok, bar_low, low_ok, zero pad
    input  logic [usrm_pkg::S_TDATA_W-1:0]   s_tdata,
    // series_start
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mean_ratio, mean_ok, zero pad
    output logic [usrm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import usrm_pkg::*;

    localparam int PB      = PRICE_BITS;
    localparam int RF      = RATIO_FRAC_BITS;
    localparam int COUNT_W = $clog2(MAX_BARS + 1);
    localparam int SUM_W   = RF + COUNT_W;
    localparam int DW      = (PB > COUNT_W) ? PB : COUNT_W;
    localparam int QUO_W   = (RF + 1 > MEAN_W) ? RF + 1 : MEAN_W;
    localparam logic [SUM_W-1:0]   RATIO_ONE = SUM_W'(1) << RF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_BARS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RANGE  = 3'd1;
    localparam logic [2:0] ST_SHADOW = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;

    logic [PB-1:0]      close_reg;
    logic [PB-1:0]      high_reg;
    logic [PB-1:0]      low_reg;
    logic               close_ok_reg;
    logic               high_ok_reg;
    logic               low_ok_reg;
    logic               start_reg;
    logic               end_reg;

    logic [PB-1:0]      prior_price_reg;
    logic               prior_ok_reg;
    logic [SUM_W-1:0]   ratio_sum_reg;
    logic [COUNT_W-1:0] kept_count_reg;

    logic [PB-1:0]      range_reg;
    logic               range_pos_reg;
    logic [PB-1:0]      top_reg;
    logic [PB-1:0]      shadow_reg;
    logic               keep_reg;
    logic               mean_mode_reg;
    logic [MEAN_W-1:0]  mean_val_reg;
    logic               mean_ok_reg;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] out_word;

    logic [PB:0]        range_diff;
    logic [PB:0]        shadow_diff;
    logic               in_fire;
    logic               out_free;

    div_ctl_t           div_ctl;
    logic [DW-1:0]      div_rem_init;
    logic [DW-1:0]      div_divisor;
    logic [SUM_W-1:0]   div_dividend;
    logic               div_done;
    logic [QUO_W-1:0]   div_quotient;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign range_diff  = {1'b0, high_reg} - {1'b0, low_reg};
    assign shadow_diff = {1'b0, high_reg} - {1'b0, top_reg};

    always_comb begin
        out_word                     = '0;
        out_word[MEAN_LSB +: MEAN_W] = mean_val_reg;
        out_word[MEAN_OK_BIT]        = mean_ok_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_RANGE;
            ST_RANGE:  state_next = ST_SHADOW;
            ST_SHADOW: state_next = ST_CHECK;
            ST_CHECK: begin
                if (keep_reg && shadow_reg < range_reg) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_done) state_next = mean_mode_reg ? ST_OUT : ST_FINISH;
            end
            ST_FINISH: begin
                if (!end_reg) begin
                    state_next = ST_IDLE;
                end else if (kept_count_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // divider command and operands
    always_comb begin
        div_ctl.load     = 1'b0;
        div_ctl.long_run = 1'b0;
        div_rem_init     = DW'(shadow_reg);
        div_divisor      = DW'(range_reg);
        div_dividend     = '0;
        case (state_reg)
            ST_CHECK: begin
                div_ctl.load = keep_reg && shadow_reg < range_reg;
            end
            ST_FINISH: begin
                div_ctl.load     = end_reg && kept_count_reg != '0;
                div_ctl.long_run = 1'b1;
                div_rem_init     = '0;
                div_divisor      = DW'(kept_count_reg);
                div_dividend     = ratio_sum_reg;
            end
            default: begin
                div_ctl.load = 1'b0;
            end
        endcase
    end

    usrm_div #(
        .REM_W       (DW),
        .DVD_W       (SUM_W),
        .QUO_W       (QUO_W),
        .SHORT_STEPS (RF),
        .LONG_STEPS  (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .divisor  (div_divisor),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prior_price_reg <= '0;
            prior_ok_reg   <= 1'b0;
            ratio_sum_reg  <= '0;
            kept_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_SHADOW: begin
                    prior_price_reg <= close_reg;
                    prior_ok_reg    <= close_ok_reg;
                    if (start_reg) begin
                        ratio_sum_reg  <= '0;
                        kept_count_reg <= '0;
                    end
                end
                ST_CHECK: begin
                    if (keep_reg && shadow_reg >= range_reg) begin
                        ratio_sum_reg  <= ratio_sum_reg + RATIO_ONE;
                        kept_count_reg <= kept_count_reg + COUNT_W'(1);
                    end
                end
                ST_DIV: begin
                    if (div_done && !mean_mode_reg) begin
                        ratio_sum_reg  <= ratio_sum_reg + SUM_W'(div_quotient[RF-1:0]);
                        kept_count_reg <= kept_count_reg + COUNT_W'(1);
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        ratio_sum_reg  <= '0;
                        kept_count_reg <= '0;
                        prior_ok_reg   <= 1'b0;
                    end
                end
                default: begin
                    prior_ok_reg <= prior_ok_reg;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    close_reg    <= PB'(s_tdata[PRICE_LSB +: PRICE_IN_W]);
                    high_reg     <= PB'(s_tdata[HIGH_LSB +: PRICE_IN_W]);
                    low_reg      <= PB'(s_tdata[LOW_LSB +: PRICE_IN_W]);
                    close_ok_reg <= s_tdata[PRICE_OK_BIT];
                    high_ok_reg  <= s_tdata[HIGH_OK_BIT];
                    low_ok_reg   <= s_tdata[LOW_OK_BIT];
                    start_reg    <= s_tuser;
                    end_reg      <= s_tlast;
                end
            end
            ST_RANGE: begin
                range_reg     <= range_diff[PB-1:0];
                range_pos_reg <= !range_diff[PB] && range_diff[PB-1:0] != '0;
                top_reg       <= (prior_price_reg > close_reg) ? prior_price_reg : close_reg;
            end
            ST_SHADOW: begin
                shadow_reg    <= shadow_diff[PB] ? '0 : shadow_diff[PB-1:0];
                keep_reg      <= !start_reg && prior_ok_reg && close_ok_reg && high_ok_reg
                                 && low_ok_reg && range_pos_reg
                                 && kept_count_reg < COUNT_MAX;
                mean_mode_reg <= 1'b0;
            end
            ST_DIV: begin
                if (div_done && mean_mode_reg) begin
                    mean_val_reg <= div_quotient[MEAN_W-1:0];
                    mean_ok_reg  <= 1'b1;
                end
            end
            ST_FINISH: begin
                mean_mode_reg <= 1'b1;
                mean_val_reg  <= '0;
                mean_ok_reg   <= 1'b0;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= out_word;
                end
            end
            default: begin
                keep_reg <= keep_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/usrm_checker.sv
`timescale 1ns / 1ps

module usrm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [usrm_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                             s_tuser,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [usrm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import usrm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty series reports a zero mean
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[MEAN_OK_BIT] |-> m_tdata[MEAN_LSB +: MEAN_W] == '0)
        else $error("nonzero mean without counted bars");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // each bar is worked on alone
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

endmodule

bind upper_shadow_ratio_mean_unit usrm_checker u_usrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
